// ----- rtl/mffd_pkg.sv -----
`timescale 1ns / 1ps
package mffd_pkg;

    localparam int ROWS   = 5;
    localparam int COLS   = 9;
    localparam int NCELLS = ROWS * COLS;
    localparam int NHW    = (ROWS + 1) * COLS;
    localparam int NVW    = ROWS * (COLS + 1);

    localparam int ROW_W  = 3;
    localparam int COL_W  = 4;
    localparam int DIST_W = 6;
    localparam int REQ_W  = 2;
    localparam int CFG_W  = 4;

    localparam int DIR_UP    = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_DOWN  = 2;
    localparam int DIR_LEFT  = 3;
    localparam int NDIR      = 4;

    localparam int OUT_COL_LSB  = ROW_W;
    localparam int OUT_DIST_LSB = ROW_W + COL_W;

    typedef logic [DIST_W-1:0] dist_t;

    localparam dist_t SENTINEL = dist_t'(NCELLS);

    typedef enum logic [REQ_W-1:0] {
        REQ_HWALL = 2'd0,
        REQ_VWALL = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic {
        CFG_TARGET_ROW = 1'b0,
        CFG_TARGET_COL = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic  seed;
        logic  step;
        logic  shift;
        dist_t level;
    } cell_ctrl_t;

    typedef struct packed {
        logic             h_we;
        logic             v_we;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             present;
    } wall_wr_t;

endpackage

// ----- rtl/mffd_cell.sv -----
`timescale 1ns / 1ps
module mffd_cell
    import mffd_pkg::*;
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic                is_target,
    input  dist_t [NDIR-1:0]    nb_dist,
    input  logic  [NDIR-1:0]    nb_open,
    input  dist_t               shift_in,
    output dist_t               cur_dist,
    output logic                changed
);

    dist_t dist_reg;
    dist_t dist_next;
    logic [NDIR-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < NDIR; i++)
        begin
            hit[i] = nb_open[i] && (nb_dist[i] == ctrl.level);
        end
        changed = ctrl.step && (dist_reg == SENTINEL) && (|hit);
    end

    always_comb
    begin
        dist_next = dist_reg;
        if (ctrl.seed)
        begin
            dist_next = is_target ? '0 : SENTINEL;
        end
        else if (changed)
        begin
            dist_next = ctrl.level + dist_t'(1);
        end
        else if (ctrl.shift)
        begin
            dist_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign cur_dist = dist_reg;

endmodule

// ----- rtl/mffd_walls.sv -----
`timescale 1ns / 1ps
module mffd_walls
    import mffd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  wall_wr_t       wr,
    output logic [NHW-1:0] hw,
    output logic [NVW-1:0] vw
);

    logic [NHW-1:0] hw_reg;
    logic [NVW-1:0] vw_reg;

    for (genvar r = 0; r <= ROWS; r++)
    begin : g_hrow
        for (genvar c = 0; c < COLS; c++)
        begin : g_hcol
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hw_reg[r*COLS+c] <= 1'b0;
                end
                else if (wr.h_we && wr.row == ROW_W'(r) && wr.col == COL_W'(c))
                begin
                    hw_reg[r*COLS+c] <= wr.present;
                end
            end
        end
    end

    for (genvar r = 0; r < ROWS; r++)
    begin : g_vrow
        for (genvar c = 0; c <= COLS; c++)
        begin : g_vcol
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vw_reg[r*(COLS+1)+c] <= 1'b0;
                end
                else if (wr.v_we && wr.row == ROW_W'(r) && wr.col == COL_W'(c))
                begin
                    vw_reg[r*(COLS+1)+c] <= wr.present;
                end
            end
        end
    end

    assign hw = hw_reg;
    assign vw = vw_reg;

endmodule

// ----- rtl/maze_flood_fill_distance_top.sv -----
// Channel  Dir  Signals                       Contents
// s        in   s_tvalid s_tready s_tuser     req_type; wall item or run item
//               s_tdata                       wall_row, wall_col, wall_present
// m        out  m_tvalid m_tready m_tdata     cell_row, cell_col, distance
//               m_tlast                       last cell of the map
// cfg      in   cfg_we cfg_index cfg_wdata    target_row, target_col
//
// Wall items are written to the wall maps on acceptance; the block stays ready.
// A run item seeds the cells in its accept cycle, then fills level by level until a
// level changes no cell or the next is ROWS*COLS, then emits ROWS*COLS items.
// Output items leave by shifting the distance chain; a stall on m holds it.
// Reset clears the wall maps, the target registers and the control state.
`timescale 1ns / 1ps
module maze_flood_fill_distance_top
    import mffd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // wall_row[2:0], wall_col[6:3], wall_present[7]
    input  logic [REQ_W-1:0] s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // cell_row[2:0], cell_col[6:3], distance[12:7], zero
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FILL = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    dist_t            level_reg, level_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] target_row_reg;
    logic [COL_W-1:0] target_col_reg;

    logic             in_acc;
    logic             out_acc;
    logic             last_cell;
    dist_t            level_plus;
    logic             any_changed;
    cell_ctrl_t       ctrl;
    wall_wr_t         wall_wr;
    logic [NHW-1:0]   hw;
    logic [NVW-1:0]   vw;

    dist_t               cell_dist [NCELLS];
    dist_t [NDIR-1:0]    nb_dist  [NCELLS];
    logic  [NDIR-1:0]    nb_open  [NCELLS];
    dist_t               shift_in [NCELLS];
    logic  [NCELLS-1:0]  changed;

    assign in_acc     = s_tvalid && s_tready;
    assign out_acc    = m_tvalid && m_tready;
    assign last_cell  = (row_reg == ROW_W'(ROWS - 1)) && (col_reg == COL_W'(COLS - 1));
    assign level_plus = level_reg + dist_t'(1);
    assign any_changed = |changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_row_reg <= '0;
            target_col_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET_ROW: target_row_reg <= cfg_wdata[ROW_W-1:0];
                CFG_TARGET_COL: target_col_reg <= cfg_wdata[COL_W-1:0];
                default:        target_row_reg <= target_row_reg;
            endcase
        end
    end

    always_comb
    begin
        wall_wr.h_we    = in_acc && (req_t'(s_tuser) == REQ_HWALL);
        wall_wr.v_we    = in_acc && (req_t'(s_tuser) == REQ_VWALL);
        wall_wr.row     = s_tdata[2:0];
        wall_wr.col     = s_tdata[6:3];
        wall_wr.present = s_tdata[7];
    end

    mffd_walls u_walls
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wall_wr),
        .hw    (hw),
        .vw    (vw)
    );

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ctrl.seed  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.shift = 1'b0;
        ctrl.level = level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req_t'(s_tuser) == REQ_RUN)
                begin
                    ctrl.seed  = 1'b1;
                    level_next = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                ctrl.step  = 1'b1;
                level_next = level_plus;
                if (!any_changed || level_plus == SENTINEL)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                ctrl.shift = m_tready;
                if (out_acc)
                begin
                    if (last_cell)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (col_reg == COL_W'(COLS - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < COLS; c++)
        begin : g_col
            localparam int K = r * COLS + c;

            if (r > 0)
            begin : g_up
                assign nb_dist[K][DIR_UP] = cell_dist[K-COLS];
                assign nb_open[K][DIR_UP] = !hw[r*COLS+c];
            end
            else
            begin : g_up_edge
                assign nb_dist[K][DIR_UP] = SENTINEL;
                assign nb_open[K][DIR_UP] = 1'b0;
            end

            if (c < COLS - 1)
            begin : g_right
                assign nb_dist[K][DIR_RIGHT] = cell_dist[K+1];
                assign nb_open[K][DIR_RIGHT] = !vw[r*(COLS+1)+c+1];
            end
            else
            begin : g_right_edge
                assign nb_dist[K][DIR_RIGHT] = SENTINEL;
                assign nb_open[K][DIR_RIGHT] = 1'b0;
            end

            if (r < ROWS - 1)
            begin : g_down
                assign nb_dist[K][DIR_DOWN] = cell_dist[K+COLS];
                assign nb_open[K][DIR_DOWN] = !hw[(r+1)*COLS+c];
            end
            else
            begin : g_down_edge
                assign nb_dist[K][DIR_DOWN] = SENTINEL;
                assign nb_open[K][DIR_DOWN] = 1'b0;
            end

            if (c > 0)
            begin : g_left
                assign nb_dist[K][DIR_LEFT] = cell_dist[K-1];
                assign nb_open[K][DIR_LEFT] = !vw[r*(COLS+1)+c];
            end
            else
            begin : g_left_edge
                assign nb_dist[K][DIR_LEFT] = SENTINEL;
                assign nb_open[K][DIR_LEFT] = 1'b0;
            end

            if (K < NCELLS - 1)
            begin : g_shift
                assign shift_in[K] = cell_dist[K+1];
            end
            else
            begin : g_shift_end
                assign shift_in[K] = SENTINEL;
            end

            mffd_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .is_target ((target_row_reg == ROW_W'(r)) && (target_col_reg == COL_W'(c))),
                .nb_dist   (nb_dist[K]),
                .nb_open   (nb_open[K]),
                .shift_in  (shift_in[K]),
                .cur_dist  (cell_dist[K]),
                .changed   (changed[K])
            );
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = last_cell;
    assign m_tdata  = {3'b000, cell_dist[0], col_reg, row_reg};

endmodule

// ----- rtl/mffd_checker.sv -----
`timescale 1ns / 1ps
module mffd_checker
    import mffd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [REQ_W-1:0] s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [15:0]      m_tdata,
    input logic             m_tlast
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output items pending");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_RUN) |=> !s_tready)
        else $error("run item did not make the block busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output continues after last item");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DIST_LSB +: DIST_W] <= SENTINEL))
        else $error("distance beyond sentinel");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output item changed");

endmodule

bind maze_flood_fill_distance_top mffd_checker u_checker (.*);
